// File: hw/rtl/fbea_pkg.sv
// shared types and constants for the five-bar elbow angle core
// angle scale, cordic arctangent table, register indexes, half-angle select codes
// no dependencies
package fbea_pkg;

  localparam int INT_FRAC = 24;
  localparam int ANG_W = 40;
  localparam int WIDE_W = 64;
  localparam int TAB_LEN = 24;
  localparam int LEN_W = 16;
  localparam int IN_W = 16;
  localparam int OUT_W = 18;

  localparam logic signed [ANG_W-1:0] ANG_90 = 40'sd1509949440;
  localparam logic signed [ANG_W-1:0] ANG_180 = 40'sd3019898880;
  localparam logic signed [ANG_W-1:0] ANG_360 = 40'sd6039797760;
  localparam logic signed [ANG_W-1:0] OUT_MAX = 40'sd131071;
  localparam logic signed [ANG_W-1:0] OUT_MIN = -40'sd131072;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // atan(2^-i) in 2^-24 degree
  localparam logic signed [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
    40'sd754974720, 40'sd445687602, 40'sd235489088, 40'sd119537938,
    40'sd60000934, 40'sd30029717, 40'sd15018523, 40'sd7509720,
    40'sd3754917, 40'sd1877466, 40'sd938734, 40'sd469367,
    40'sd234684, 40'sd117342, 40'sd58671, 40'sd29335,
    40'sd14668, 40'sd7334, 40'sd3667, 40'sd1833,
    40'sd917, 40'sd458, 40'sd229, 40'sd115
  };

  typedef enum logic [2:0] {
    REG_HALF_BASE      = 3'd0,
    REG_FIRST_PROX     = 3'd1,
    REG_SECOND_PROX    = 3'd2,
    REG_FIRST_DISTAL   = 3'd3,
    REG_SECOND_DISTAL  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    HALF_ATAN,
    HALF_ZERO,
    HALF_RIGHT,
    HALF_NONE
  } half_sel_t;

endpackage

// File: hw/rtl/fbea_delay.sv
// enable-gated delay line for side data that rides along the pipeline
// no package dependencies
module fbea_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

// File: hw/rtl/fbea_isqrt.sv
// pipelined floor square root, one result bit per stage
// no package dependencies
module fbea_isqrt #(
  parameter int IN_W = 64
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   din,
  output logic [IN_W/2-1:0] root
);

  localparam int RW = IN_W / 2;

  logic [IN_W-1:0] rem [RW+1];
  logic [IN_W-1:0] acc [RW+1];

  assign rem[0] = din;
  assign acc[0] = '0;

  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam logic [IN_W-1:0] BIT = IN_W'(1) << (IN_W - 2 - 2 * j);
    logic [IN_W:0] trial;
    assign trial = {1'b0, acc[j]} + {1'b0, BIT};
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem[j]} >= trial) begin
          rem[j+1] <= rem[j] - trial[IN_W-1:0];
          acc[j+1] <= (acc[j] >> 1) + BIT;
        end else begin
          rem[j+1] <= rem[j];
          acc[j+1] <= acc[j] >> 1;
        end
      end
    end
  end

  assign root = acc[RW][RW-1:0];

endmodule

// File: hw/rtl/fbea_sincos.sv
// pipelined rotation cordic: angle in 2^-24 degree to cos and sin in q30
// uses fbea_pkg for the arctangent table and angle constants
module fbea_sincos #(
  parameter int ITER = 16
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [fbea_pkg::ANG_W-1:0] angle,
  output logic signed [33:0]                cos_q,
  output logic signed [33:0]                sin_q
);
  import fbea_pkg::*;

  logic signed [ANG_W-1:0] wrapped;
  logic signed [ANG_W-1:0] z [ITER+1];
  logic signed [33:0]      x [ITER+1];
  logic signed [33:0]      y [ITER+1];
  logic                    flip [ITER+1];

  // wrap once into (-180, 180]
  always_ff @(posedge clk) begin
    if (en) begin
      if (angle > ANG_180) begin
        wrapped <= angle - ANG_360;
      end else if (angle <= -ANG_180) begin
        wrapped <= angle + ANG_360;
      end else begin
        wrapped <= angle;
      end
    end
  end

  // fold into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= CORDIC_GAIN;
      y[0] <= '0;
      if (wrapped > ANG_90) begin
        z[0]    <= wrapped - ANG_180;
        flip[0] <= 1'b1;
      end else if (wrapped < -ANG_90) begin
        z[0]    <= wrapped + ANG_180;
        flip[0] <= 1'b1;
      end else begin
        z[0]    <= wrapped;
        flip[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        flip[i+1] <= flip[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ATAN_TAB[i];
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ATAN_TAB[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= flip[ITER] ? -x[ITER] : x[ITER];
      sin_q <= flip[ITER] ? -y[ITER] : y[ITER];
    end
  end

endmodule

// File: hw/rtl/fbea_vector.sv
// pipelined vectoring cordic: atan2(y, x) in 2^-24 degree
// uses fbea_pkg for the arctangent table and angle constants
module fbea_vector #(
  parameter int ITER = 16,
  parameter int IW = 28
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [IW-1:0]              y_in,
  input  logic signed [IW-1:0]              x_in,
  output logic signed [fbea_pkg::ANG_W-1:0] angle
);
  import fbea_pkg::*;

  logic signed [WIDE_W-1:0] x_ext;
  logic signed [WIDE_W-1:0] y_ext;
  logic signed [WIDE_W-1:0] x [ITER+1];
  logic signed [WIDE_W-1:0] y [ITER+1];
  logic signed [ANG_W-1:0]  z [ITER+1];
  logic                     zero [ITER+1];

  assign x_ext = WIDE_W'(x_in);
  assign y_ext = WIDE_W'(y_in);

  // left half plane: start at +-180 and mirror the vector
  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        z[0] <= (y_in >= 0) ? ANG_180 : -ANG_180;
        x[0] <= (-x_ext) <<< 30;
        y[0] <= (-y_ext) <<< 30;
      end else begin
        z[0] <= '0;
        x[0] <= x_ext <<< 30;
        y[0] <= y_ext <<< 30;
      end
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
        if (y[i] >= 0) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ATAN_TAB[i];
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ATAN_TAB[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= zero[ITER] ? '0 : z[ITER];
    end
  end

endmodule

// File: hw/rtl/five_bar_elbow_angle_core.sv
// five-bar linkage distal joint angle: top level, config registers, loop closure math
// uses fbea_pkg, fbea_sincos, fbea_vector, fbea_isqrt, fbea_delay
//
//   channel  signals                                     direction
//   in       in_valid/in_ready, first/second_motor_angle word in
//   out      out_valid/out_ready, elbow_angle, reachable word out
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data    register write
//
// one word per cycle while no output word waits; the pipeline depth is set by the
// chain of two 32-stage square roots and two cordic pipelines in series.
// the whole pipeline advances together; when the output word is not taken
// every stage holds and in_ready drops. reset clears the valid line and
// loads the register defaults. cfg_ready is always high.
module five_bar_elbow_angle_core #(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [fbea_pkg::IN_W-1:0] first_motor_angle,
  input  logic signed [fbea_pkg::IN_W-1:0] second_motor_angle,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [fbea_pkg::OUT_W-1:0] elbow_angle,
  output logic                             reachable,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [2:0]                       cfg_index,
  input  logic [fbea_pkg::LEN_W-1:0]       cfg_data
);
  import fbea_pkg::*;

  localparam int ASH = INT_FRAC - ANGLE_FRAC_BITS;
  localparam int VW = 28;
  localparam int LA = CORDIC_ITERATIONS + 2;
  localparam int TV = CORDIC_ITERATIONS + 6;
  localparam int TH = TV + 70 + LA;
  localparam int LAT = TH + 2;
  localparam logic signed [ANG_W-1:0] RND = ANG_W'(1) <<< (ASH - 1);

  logic en;
  logic [LAT-1:0] vld;

  logic [LEN_W-1:0] half_base_length;
  logic [LEN_W-1:0] first_proximal_length;
  logic [LEN_W-1:0] second_proximal_length;
  logic [LEN_W-1:0] first_distal_length;
  logic [LEN_W-1:0] second_distal_length;

  assign en = !vld[LAT-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[LAT-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_base_length       <= 16'd570;
      first_proximal_length  <= 16'd3686;
      second_proximal_length <= 16'd3686;
      first_distal_length    <= 16'd4992;
      second_distal_length   <= 16'd4992;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HALF_BASE:     half_base_length       <= cfg_data;
        REG_FIRST_PROX:    first_proximal_length  <= cfg_data;
        REG_SECOND_PROX:   second_proximal_length <= cfg_data;
        REG_FIRST_DISTAL:  first_distal_length    <= cfg_data;
        REG_SECOND_DISTAL: second_distal_length   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage: motor angles to 2^-24 degree
  logic signed [ANG_W-1:0] a1;
  logic signed [ANG_W-1:0] a2;

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= ANG_W'(first_motor_angle) <<< ASH;
      a2 <= ANG_W'(second_motor_angle) <<< ASH;
    end
  end

  logic signed [33:0] c1, s1, c2, s2;

  fbea_sincos #(.ITER(CORDIC_ITERATIONS)) u_sincos1 (
    .clk(clk), .en(en), .angle(a1), .cos_q(c1), .sin_q(s1)
  );

  fbea_sincos #(.ITER(CORDIC_ITERATIONS)) u_sincos2 (
    .clk(clk), .en(en), .angle(a2), .cos_q(c2), .sin_q(s2)
  );

  // link components in 2^-16 unit
  logic signed [50:0] m1c, m1s, m2c, m2s;
  logic signed [VW-1:0] p1c, p1s, p2c, p2s;
  logic signed [VW-1:0] vx, vy;

  always_comb begin
    m1c = $signed({1'b0, first_proximal_length}) * c1;
    m1s = $signed({1'b0, first_proximal_length}) * s1;
    m2c = $signed({1'b0, second_proximal_length}) * c2;
    m2s = $signed({1'b0, second_proximal_length}) * s2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1c <= VW'(m1c >>> 22);
      p1s <= VW'(m1s >>> 22);
      p2c <= VW'(m2c >>> 22);
      p2s <= VW'(m2s >>> 22);
      vx  <= p1c + $signed(VW'({half_base_length, 9'd0})) - p2c;
      vy  <= p1s - p2s;
    end
  end

  logic signed [ANG_W-1:0] dir;
  logic signed [ANG_W-1:0] dir_d;

  fbea_vector #(.ITER(CORDIC_ITERATIONS), .IW(VW)) u_dir (
    .clk(clk), .en(en), .y_in(vy), .x_in(vx), .angle(dir)
  );

  fbea_delay #(.WIDTH(ANG_W), .DEPTH(TH - TV - LA)) u_dir_dly (
    .clk(clk), .en(en), .din(dir), .dout(dir_d)
  );

  // vector length
  logic [WIDE_W-1:0] sqx, sqy, sq_sum;
  logic [31:0]       len;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx    <= WIDE_W'(vx) * WIDE_W'(vx);
      sqy    <= WIDE_W'(vy) * WIDE_W'(vy);
      sq_sum <= sqx + sqy;
    end
  end

  fbea_isqrt #(.IN_W(WIDE_W)) u_len (
    .clk(clk), .en(en), .din(sq_sum), .root(len)
  );

  // half-angle numerator and denominator
  logic [32:0]              len_p;
  logic signed [33:0]       len_m;
  logic [WIDE_W-1:0]        sq_p, sq_m, d4_sq;
  logic signed [WIDE_W-1:0] num, den;
  logic [WIDE_W-1:0]        num_abs, den_abs;
  half_sel_t                sel, sel_d;
  logic [1:0]               sel_bits;

  always_ff @(posedge clk) begin
    if (en) begin
      len_p   <= 33'(len) + 33'({first_distal_length, 8'd0});
      len_m   <= $signed(34'(len)) - $signed(34'({first_distal_length, 8'd0}));
      sq_p    <= WIDE_W'(len_p) * WIDE_W'(len_p);
      sq_m    <= WIDE_W'(len_m) * WIDE_W'(len_m);
      d4_sq   <= WIDE_W'({second_distal_length, 8'd0}) *
                 WIDE_W'({second_distal_length, 8'd0});
      num     <= $signed(sq_p - d4_sq);
      den     <= $signed(d4_sq - sq_m);
      num_abs <= (num < 0) ? WIDE_W'(-num) : WIDE_W'(num);
      den_abs <= (den < 0) ? WIDE_W'(-den) : WIDE_W'(den);
      // opposite signs or 0/0 do not close the loop
      if ((num == 0 && den == 0) || (num > 0 && den < 0) || (num < 0 && den > 0)) begin
        sel <= HALF_NONE;
      end else if (den == 0) begin
        sel <= HALF_RIGHT;
      end else if (num == 0) begin
        sel <= HALF_ZERO;
      end else begin
        sel <= HALF_ATAN;
      end
    end
  end

  logic [31:0]             root_n, root_d;
  logic signed [ANG_W-1:0] half_z;

  fbea_isqrt #(.IN_W(WIDE_W)) u_num_root (
    .clk(clk), .en(en), .din(num_abs), .root(root_n)
  );

  fbea_isqrt #(.IN_W(WIDE_W)) u_den_root (
    .clk(clk), .en(en), .din(den_abs), .root(root_d)
  );

  fbea_vector #(.ITER(CORDIC_ITERATIONS), .IW(33)) u_half (
    .clk(clk), .en(en), .y_in($signed({1'b0, root_n})), .x_in($signed({1'b0, root_d})),
    .angle(half_z)
  );

  fbea_delay #(.WIDTH(2), .DEPTH(LA + 32)) u_sel_dly (
    .clk(clk), .en(en), .din(sel), .dout(sel_bits)
  );

  assign sel_d = half_sel_t'(sel_bits);

  logic [ANG_W-1:0] a1_d;

  fbea_delay #(.WIDTH(ANG_W), .DEPTH(TH - 1)) u_a1_dly (
    .clk(clk), .en(en), .din(a1), .dout(a1_d)
  );

  // closure sum, then round and saturate
  logic signed [ANG_W-1:0] half_v;
  logic signed [ANG_W-1:0] theta;
  logic signed [ANG_W-1:0] q;
  logic                    reach_t;

  always_comb begin
    unique case (sel_d)
      HALF_ATAN:  half_v = half_z;
      HALF_RIGHT: half_v = ANG_90;
      HALF_ZERO:  half_v = '0;
      HALF_NONE:  half_v = '0;
    endcase
  end

  assign q = (theta + RND) >>> ASH;

  always_ff @(posedge clk) begin
    if (en) begin
      theta   <= dir_d - $signed(a1_d) + (half_v <<< 1);
      reach_t <= (sel_d != HALF_NONE);
      reachable <= reach_t;
      if (!reach_t) begin
        elbow_angle <= '0;
      end else if (q > OUT_MAX) begin
        elbow_angle <= OUT_MAX[OUT_W-1:0];
      end else if (q < OUT_MIN) begin
        elbow_angle <= OUT_MIN[OUT_W-1:0];
      end else begin
        elbow_angle <= q[OUT_W-1:0];
      end
    end
  end

  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reachable |-> elbow_angle == '0)
    else $error("unreachable word carries a nonzero angle");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid line moved while stalled");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted word missing from first stage");

  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule
